[rtl/core/fot_pkg.sv]
package fot_pkg;

  // Table geometry.
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned HALF  = DEPTH / 2;
  localparam int unsigned KEEP  = DEPTH - HALF;

  // The occupancy counter holds DEPTH itself and is never narrower than the report field.
  localparam int unsigned OPEN_W = 11;
  localparam int unsigned OCC_W  = ($clog2(DEPTH + 1) > OPEN_W) ? $clog2(DEPTH + 1) : OPEN_W;

  // The match search works in groups of cells.
  localparam int unsigned GRP_W = 5;
  localparam int unsigned GRP   = 1 << GRP_W;
  localparam int unsigned NGRP  = (DEPTH + GRP - 1) / GRP;
  localparam int unsigned NGW   = $clog2(NGRP);
  localparam int unsigned PAD   = NGRP * GRP;

  // Field widths.
  localparam int unsigned ID_W  = 64;
  localparam int unsigned TS_W  = 64;
  localparam int unsigned WIN_W = 63;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned MODE_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(1000000);

  // Event kinds.
  localparam logic [MODE_W-1:0] MODE_REST    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRADE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL  = 3'd3;

  // Where a cell takes its next contents from.
  typedef enum logic [1:0] {
    SRC_HOLD,
    SRC_NEXT,
    SRC_FAR,
    SRC_NEW
  } cell_src_e;

  typedef struct packed {
    cell_src_e src;
    logic      cmp_en;
    logic      live;
  } cell_cmd_t;

  // Stage enables of the match search.
  typedef struct packed {
    logic pfx_en;
    logic sel_en;
    logic gsum_en;
    logic tsum_en;
  } srch_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_PFX,
    ST_SEL,
    ST_GSUM,
    ST_TSUM,
    ST_JUDGE
  } state_e;

  // Saturating increment of an event counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/core/fot_cell.sv]
module fot_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fot_pkg::cell_cmd_t            cmd_i,
  input  logic [fot_pkg::ID_W-1:0]      key_i,
  input  logic [fot_pkg::ID_W-1:0]      new_id_i,
  input  logic [fot_pkg::TS_W-1:0]      new_time_i,
  input  logic [fot_pkg::ID_W-1:0]      next_id_i,
  input  logic [fot_pkg::TS_W-1:0]      next_time_i,
  input  logic [fot_pkg::ID_W-1:0]      far_id_i,
  input  logic [fot_pkg::TS_W-1:0]      far_time_i,
  output logic [fot_pkg::ID_W-1:0]      id_o,
  output logic [fot_pkg::TS_W-1:0]      time_o,
  output logic                          match_o
);

  logic [fot_pkg::ID_W-1:0] id_q;
  logic [fot_pkg::TS_W-1:0] time_q;
  logic                     match_q;

  // Entry contents move along the chain or are loaded from the request.
  always_ff @(posedge clk_i) begin
    case (cmd_i.src)
      fot_pkg::SRC_NEXT: begin
        id_q   <= next_id_i;
        time_q <= next_time_i;
      end
      fot_pkg::SRC_FAR: begin
        id_q   <= far_id_i;
        time_q <= far_time_i;
      end
      fot_pkg::SRC_NEW: begin
        id_q   <= new_id_i;
        time_q <= new_time_i;
      end
      default: begin
        id_q   <= id_q;
        time_q <= time_q;
      end
    endcase
  end

  // A held entry flags a match against the cancel key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      match_q <= cmd_i.live && (id_q == key_i);
    end
  end

  assign id_o    = id_q;
  assign time_o  = time_q;
  assign match_o = match_q;

endmodule

[rtl/core/fot_search.sv]
module fot_search (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  fot_pkg::srch_ctl_t                           ctl_i,
  input  logic [fot_pkg::DEPTH-1:0]                    match_i,
  input  logic [fot_pkg::DEPTH-1:0][fot_pkg::TS_W-1:0] times_i,
  output logic [fot_pkg::DEPTH-1:0]                    shift_o,
  output logic                                         matched_o,
  output logic [fot_pkg::TS_W-1:0]                     rest_time_o
);

  logic [fot_pkg::PAD-1:0]                    mpad;
  logic [fot_pkg::PAD-1:0][fot_pkg::TS_W-1:0] tpad;

  logic [fot_pkg::NGRP-1:0] grp_any_d, grp_any_q;
  logic [fot_pkg::PAD-1:0]  loc_d, loc_q;
  logic [fot_pkg::PAD-1:0]  shift_d, shift_q;
  logic [fot_pkg::PAD-1:0]  onehot_d, onehot_q;
  logic                     matched_q;
  logic [fot_pkg::NGRP-1:0][fot_pkg::TS_W-1:0] grp_time_d, grp_time_q;
  logic [fot_pkg::TS_W-1:0] rest_time_d, rest_time_q;

  // Inclusive prefix OR inside one group, in log steps.
  function automatic logic [fot_pkg::GRP-1:0] loc_prefix(input logic [fot_pkg::GRP-1:0] v);
    logic [fot_pkg::GRP-1:0] r;
    r = v;
    for (int l = 0; l < fot_pkg::GRP_W; l++) begin
      r = r | (r << (1 << l));
    end
    return r;
  endfunction

  // Inclusive prefix OR across the groups, in log steps.
  function automatic logic [fot_pkg::NGRP-1:0] grp_prefix(input logic [fot_pkg::NGRP-1:0] v);
    logic [fot_pkg::NGRP-1:0] r;
    r = v;
    for (int l = 0; l < fot_pkg::NGW; l++) begin
      r = r | (r << (1 << l));
    end
    return r;
  endfunction

  // Pad the cell row to whole groups.
  assign mpad = fot_pkg::PAD'(match_i);
  always_comb begin
    for (int k = 0; k < fot_pkg::PAD; k++) begin
      tpad[k] = (k < fot_pkg::DEPTH) ? times_i[k] : '0;
    end
  end

  // First stage: per group, any match and the running OR of matches.
  always_comb begin
    for (int g = 0; g < fot_pkg::NGRP; g++) begin
      grp_any_d[g]                      = |mpad[g*fot_pkg::GRP +: fot_pkg::GRP];
      loc_d[g*fot_pkg::GRP +: fot_pkg::GRP] = loc_prefix(mpad[g*fot_pkg::GRP +: fot_pkg::GRP]);
    end
  end

  // Second stage: cells at or after the oldest match, and the oldest match itself.
  always_comb begin
    logic [fot_pkg::NGRP-1:0] gbefore;
    logic                     prev;
    gbefore = grp_prefix(grp_any_q) << 1;
    for (int k = 0; k < fot_pkg::PAD; k++) begin
      prev        = ((k % fot_pkg::GRP) != 0) ? loc_q[(k > 0) ? k - 1 : 0] : 1'b0;
      shift_d[k]  = gbefore[k >> fot_pkg::GRP_W] | loc_q[k];
      onehot_d[k] = loc_q[k] & ~prev & ~gbefore[k >> fot_pkg::GRP_W];
    end
  end

  // Third stage: the rest time of the oldest match, gathered per group.
  always_comb begin
    for (int g = 0; g < fot_pkg::NGRP; g++) begin
      grp_time_d[g] = '0;
      for (int j = 0; j < fot_pkg::GRP; j++) begin
        grp_time_d[g] = grp_time_d[g] |
          (tpad[g*fot_pkg::GRP + j] & {fot_pkg::TS_W{onehot_q[g*fot_pkg::GRP + j]}});
      end
    end
  end

  // Fourth stage: gather across groups.
  always_comb begin
    rest_time_d = '0;
    for (int g = 0; g < fot_pkg::NGRP; g++) begin
      rest_time_d = rest_time_d | grp_time_q[g];
    end
  end

  // Search control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      loc_q     <= '0;
      shift_q   <= '0;
      onehot_q  <= '0;
      matched_q <= 1'b0;
    end else begin
      if (ctl_i.pfx_en) begin
        grp_any_q <= grp_any_d;
        loc_q     <= loc_d;
      end
      if (ctl_i.sel_en) begin
        shift_q   <= shift_d;
        onehot_q  <= onehot_d;
        matched_q <= |grp_any_q;
      end
    end
  end

  // Gathered time values.
  always_ff @(posedge clk_i) begin
    if (ctl_i.gsum_en) begin
      grp_time_q <= grp_time_d;
    end
    if (ctl_i.tsum_en) begin
      rest_time_q <= rest_time_d;
    end
  end

  assign shift_o     = shift_q[fot_pkg::DEPTH-1:0];
  assign matched_o   = matched_q;
  assign rest_time_o = rest_time_q;

endmodule

[rtl/core/fleeting_order_tracker.sv]
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    mode_i, order_id_i, timestamp_i
// output    out        out_valid_o / out_ready_i  flags, five counters, open_entries_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (fleeting window)
//
// A rest, trade, replace or unknown event passes through the execute state after its
// acceptance; a cancel passes through the compare, prefix, select and two gather stages
// of the match search and the fleeting test before its result is offered.
// Reset clears the counters and the occupancy and returns the window to its reset value;
// table contents are not cleared and only entries below the occupancy are ever used.
// A new request is taken while the previous result waits; the block holds before loading
// the output register when that result is still not taken.
module fleeting_order_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fot_pkg::MODE_W-1:0]        mode_i,
  input  logic [fot_pkg::ID_W-1:0]          order_id_i,
  input  logic signed [fot_pkg::TS_W-1:0]   timestamp_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fot_pkg::WIN_W-1:0]         cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              cancel_matched_o,
  output logic                              fleeting_hit_o,
  output logic                              evicted_o,
  output logic [fot_pkg::CNT_W-1:0]         rest_count_o,
  output logic [fot_pkg::CNT_W-1:0]         trade_count_o,
  output logic [fot_pkg::CNT_W-1:0]         replace_count_o,
  output logic [fot_pkg::CNT_W-1:0]         cancel_count_o,
  output logic [fot_pkg::CNT_W-1:0]         fleeting_count_o,
  output logic [fot_pkg::OPEN_W-1:0]        open_entries_o
);

  fot_pkg::state_e state_d, state_q;

  logic [fot_pkg::MODE_W-1:0] mode_q;
  logic [fot_pkg::ID_W-1:0]   id_q;
  logic [fot_pkg::TS_W-1:0]   ts_q;
  logic [fot_pkg::OCC_W-1:0]  occ_q;
  logic [fot_pkg::WIN_W-1:0]  window_q;
  logic [fot_pkg::CNT_W-1:0]  rests_q, trades_q, replaces_q, cancels_q, fleets_q;
  logic                       flg_match_q, flg_hit_q, flg_evict_q;

  logic                       out_valid_q;
  logic                       out_match_q, out_hit_q, out_evict_q;
  logic [fot_pkg::CNT_W-1:0]  out_rests_q, out_trades_q, out_replaces_q;
  logic [fot_pkg::CNT_W-1:0]  out_cancels_q, out_fleets_q;
  logic [fot_pkg::OPEN_W-1:0] out_open_q;

  logic in_accept, out_load, out_free, finish;
  logic do_exec, do_cmp, do_shift, do_judge, do_rest, full;
  logic hit;
  fot_pkg::srch_ctl_t srch_ctl;

  logic [fot_pkg::DEPTH-1:0][fot_pkg::ID_W-1:0] cell_id;
  logic [fot_pkg::DEPTH-1:0][fot_pkg::TS_W-1:0] cell_time;
  logic [fot_pkg::DEPTH-1:0]                    cell_match;
  logic [fot_pkg::DEPTH-1:0]                    shift;
  logic                                         matched;
  logic [fot_pkg::TS_W-1:0]                     rest_time;

  assign full     = (occ_q == fot_pkg::OCC_W'(fot_pkg::DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fot_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (mode_i == fot_pkg::MODE_CANCEL) ? fot_pkg::ST_CMP : fot_pkg::ST_EXEC;
        end
      end
      fot_pkg::ST_EXEC:  state_d = out_free ? fot_pkg::ST_IDLE : fot_pkg::ST_JUDGE;
      fot_pkg::ST_CMP:   state_d = fot_pkg::ST_PFX;
      fot_pkg::ST_PFX:   state_d = fot_pkg::ST_SEL;
      fot_pkg::ST_SEL:   state_d = fot_pkg::ST_GSUM;
      fot_pkg::ST_GSUM:  state_d = fot_pkg::ST_TSUM;
      fot_pkg::ST_TSUM:  state_d = fot_pkg::ST_JUDGE;
      fot_pkg::ST_JUDGE: state_d = out_free ? fot_pkg::ST_IDLE : fot_pkg::ST_JUDGE;
      default:           state_d = fot_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    do_exec    = 1'b0;
    do_cmp     = 1'b0;
    do_shift   = 1'b0;
    do_judge   = 1'b0;
    finish     = 1'b0;
    srch_ctl   = '0;
    case (state_q)
      fot_pkg::ST_IDLE:  in_ready_o = 1'b1;
      fot_pkg::ST_EXEC: begin
        do_exec = 1'b1;
        finish  = 1'b1;
      end
      fot_pkg::ST_CMP:   do_cmp = 1'b1;
      fot_pkg::ST_PFX:   srch_ctl.pfx_en = 1'b1;
      fot_pkg::ST_SEL:   srch_ctl.sel_en = 1'b1;
      fot_pkg::ST_GSUM: begin
        srch_ctl.gsum_en = 1'b1;
        do_shift         = matched;
      end
      fot_pkg::ST_TSUM:  srch_ctl.tsum_en = 1'b1;
      fot_pkg::ST_JUDGE: begin
        do_judge = 1'b1;
        finish   = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_accept   = in_valid_i && in_ready_o;
  assign out_load    = finish && out_free;
  assign do_rest     = do_exec && (mode_q == fot_pkg::MODE_REST);
  assign cfg_ready_o = 1'b1;

  // Fleeting test of a matched cancel; with both times positive they compare as unsigned.
  always_comb begin
    logic [fot_pkg::TS_W-1:0] diff;
    logic                     ts_pos, rt_pos;
    diff   = ts_q - rest_time;
    ts_pos = (ts_q != '0) && !ts_q[fot_pkg::TS_W-1];
    rt_pos = (rest_time != '0) && !rest_time[fot_pkg::TS_W-1];
    hit    = 1'b0;
    if (flg_match_q && ts_pos && rt_pos) begin
      if (ts_q >= rest_time) begin
        hit = (diff < {1'b0, window_q});
      end else begin
        hit = 1'b1;
      end
    end
  end

  // Request registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      id_q   <= order_id_i;
      ts_q   <= $unsigned(timestamp_i);
    end
  end

  // Sequencer state, counters, occupancy and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fot_pkg::ST_IDLE;
      occ_q       <= '0;
      window_q    <= fot_pkg::WINDOW_RST;
      rests_q     <= '0;
      trades_q    <= '0;
      replaces_q  <= '0;
      cancels_q   <= '0;
      fleets_q    <= '0;
      flg_match_q <= 1'b0;
      flg_hit_q   <= 1'b0;
      flg_evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
      if (in_accept) begin
        flg_match_q <= 1'b0;
        flg_hit_q   <= 1'b0;
        flg_evict_q <= 1'b0;
      end
      if (do_exec) begin
        case (mode_q)
          fot_pkg::MODE_REST: begin
            rests_q     <= fot_pkg::sat_inc(rests_q);
            flg_evict_q <= full;
            occ_q       <= full ? fot_pkg::OCC_W'(fot_pkg::KEEP + 1) : occ_q + 1'b1;
          end
          fot_pkg::MODE_TRADE:   trades_q   <= fot_pkg::sat_inc(trades_q);
          fot_pkg::MODE_REPLACE: replaces_q <= fot_pkg::sat_inc(replaces_q);
          default: ;
        endcase
      end
      if (do_cmp) begin
        cancels_q <= fot_pkg::sat_inc(cancels_q);
      end
      if (do_shift) begin
        occ_q       <= occ_q - 1'b1;
        flg_match_q <= 1'b1;
      end
      if (do_judge && !flg_hit_q && hit) begin
        flg_hit_q <= 1'b1;
        fleets_q  <= fot_pkg::sat_inc(fleets_q);
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, with this event's flag and counter updates folded in.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q    <= flg_match_q;
      out_hit_q      <= flg_hit_q || (do_judge && hit);
      out_evict_q    <= flg_evict_q || (do_rest && full);
      out_rests_q    <= do_rest ? fot_pkg::sat_inc(rests_q) : rests_q;
      out_trades_q   <= (do_exec && (mode_q == fot_pkg::MODE_TRADE)) ?
                        fot_pkg::sat_inc(trades_q) : trades_q;
      out_replaces_q <= (do_exec && (mode_q == fot_pkg::MODE_REPLACE)) ?
                        fot_pkg::sat_inc(replaces_q) : replaces_q;
      out_cancels_q  <= cancels_q;
      out_fleets_q   <= (do_judge && !flg_hit_q && hit) ? fot_pkg::sat_inc(fleets_q) : fleets_q;
      if (do_rest) begin
        out_open_q <= full ? fot_pkg::OPEN_W'(fot_pkg::KEEP + 1) : fot_pkg::OPEN_W'(occ_q + 1'b1);
      end else begin
        out_open_q <= occ_q[fot_pkg::OPEN_W-1:0];
      end
    end
  end

  // Row of table cells.
  for (genvar k = 0; k < fot_pkg::DEPTH; k++) begin : g_cell
    logic [fot_pkg::ID_W-1:0] nxt_id, far_id;
    logic [fot_pkg::TS_W-1:0] nxt_time, far_time;
    fot_pkg::cell_cmd_t       cmd;

    if (k + 1 < fot_pkg::DEPTH) begin : g_nxt
      assign nxt_id   = cell_id[k+1];
      assign nxt_time = cell_time[k+1];
    end else begin : g_last
      assign nxt_id   = cell_id[k];
      assign nxt_time = cell_time[k];
    end

    if (k + fot_pkg::HALF < fot_pkg::DEPTH) begin : g_far
      assign far_id   = cell_id[k+fot_pkg::HALF];
      assign far_time = cell_time[k+fot_pkg::HALF];
    end else begin : g_nofar
      assign far_id   = cell_id[k];
      assign far_time = cell_time[k];
    end

    // Per-cell command: eviction hop, append, or close-up after a cancel.
    always_comb begin
      cmd.src    = fot_pkg::SRC_HOLD;
      cmd.cmp_en = do_cmp;
      cmd.live   = (fot_pkg::OCC_W'(k) < occ_q);
      if (do_rest) begin
        if (full) begin
          if (k < fot_pkg::KEEP) begin
            cmd.src = fot_pkg::SRC_FAR;
          end else if (k == fot_pkg::KEEP) begin
            cmd.src = fot_pkg::SRC_NEW;
          end
        end else if (fot_pkg::OCC_W'(k) == occ_q) begin
          cmd.src = fot_pkg::SRC_NEW;
        end
      end
      if (do_shift && shift[k] && (k + 1 < fot_pkg::DEPTH)) begin
        cmd.src = fot_pkg::SRC_NEXT;
      end
    end

    fot_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (id_q),
      .new_id_i    (id_q),
      .new_time_i  (ts_q),
      .next_id_i   (nxt_id),
      .next_time_i (nxt_time),
      .far_id_i    (far_id),
      .far_time_i  (far_time),
      .id_o        (cell_id[k]),
      .time_o      (cell_time[k]),
      .match_o     (cell_match[k])
    );
  end

  // Oldest-match search over the row.
  fot_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (srch_ctl),
    .match_i     (cell_match),
    .times_i     (cell_time),
    .shift_o     (shift),
    .matched_o   (matched),
    .rest_time_o (rest_time)
  );

  assign out_valid_o      = out_valid_q;
  assign cancel_matched_o = out_match_q;
  assign fleeting_hit_o   = out_hit_q;
  assign evicted_o        = out_evict_q;
  assign rest_count_o     = out_rests_q;
  assign trade_count_o    = out_trades_q;
  assign replace_count_o  = out_replaces_q;
  assign cancel_count_o   = out_cancels_q;
  assign fleeting_count_o = out_fleets_q;
  assign open_entries_o   = out_open_q;

endmodule

[rtl/core/fot_checker.sv]
module fot_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              cancel_matched_o,
  input logic                              fleeting_hit_o,
  input logic                              evicted_o,
  input logic [fot_pkg::OPEN_W-1:0]        open_entries_o
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A fleeting cancel must have removed an entry.
  a_hit_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fleeting_hit_o |-> cancel_matched_o)
    else $error("fleeting hit without a matched cancel");

  // One event is either a rest or a cancel, never both.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cancel_matched_o && evicted_o))
    else $error("cancel match and eviction on one event");

  // An eviction leaves just over half the table occupied.
  a_evict_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |->
      (open_entries_o == fot_pkg::OPEN_W'(fot_pkg::KEEP + 1)))
    else $error("wrong occupancy after eviction");

endmodule

bind fleeting_order_tracker fot_checker u_fot_checker (.*);

[dv/fot_checker.sv]
`timescale 1ns / 1ps

// Watches the request, configuration and report channels of the fleeting order
// tracker, keeps its own copy of the open-order book and the event counters, and
// compares every report taken from the block with the oldest predicted one.
module tb_fot_checker
  import fot_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [ID_W-1:0]          order_id_i,
  input  logic [TS_W-1:0]          timestamp_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [WIN_W-1:0]         cfg_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     cancel_matched_i,
  input  logic                     fleeting_hit_i,
  input  logic                     evicted_i,
  input  logic [CNT_W-1:0]         rest_count_i,
  input  logic [CNT_W-1:0]         trade_count_i,
  input  logic [CNT_W-1:0]         replace_count_i,
  input  logic [CNT_W-1:0]         cancel_count_i,
  input  logic [CNT_W-1:0]         fleeting_count_i,
  input  logic [OPEN_W-1:0]        open_entries_i,
  output int unsigned              mismatches_o,
  output int unsigned              pending_o,
  output int unsigned              reports_o,
  output int unsigned              match_total_o,
  output int unsigned              fleeting_o,
  output int unsigned              evictions_o
);

  typedef struct packed {
    logic              matched;
    logic              hit;
    logic              evicted;
    logic [CNT_W-1:0]  rests;
    logic [CNT_W-1:0]  trades;
    logic [CNT_W-1:0]  replaces;
    logic [CNT_W-1:0]  cancels;
    logic [CNT_W-1:0]  fleets;
    logic [OPEN_W-1:0] open;
  } order_report_t;

  // Shadow of the open-order book, oldest entry at the front.
  logic [ID_W-1:0]  book_ids[$];
  logic [TS_W-1:0]  book_times[$];
  logic [CNT_W-1:0] rests_n, trades_n, replaces_n, cancels_n, fleets_n;
  logic [WIN_W-1:0] window;
  order_report_t    report_q[$];

  int unsigned mismatches  = 0;
  int unsigned reports     = 0;
  int unsigned match_total = 0;
  int unsigned fleets_hit  = 0;
  int unsigned evictions   = 0;

  assign mismatches_o  = mismatches;
  assign reports_o     = reports;
  assign match_total_o = match_total;
  assign fleeting_o    = fleets_hit;
  assign evictions_o   = evictions;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic known_time(input logic [TS_W-1:0] t);
    return !t[TS_W-1] && (t != '0);
  endfunction

  // Applies one order event to the shadow book and returns the report it causes.
  function automatic order_report_t predict_report(input logic [MODE_W-1:0] mode,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [TS_W-1:0] ts);
    order_report_t   rpt;
    int              idx;
    int              k;
    logic [TS_W-1:0] rest_ts;
    logic [TS_W-1:0] diff;
    rpt = '0;
    idx = -1;
    case (mode)
      MODE_REST: begin
        rests_n = bump(rests_n);
        // A full book first loses its older half.
        if (book_ids.size() >= DEPTH) begin
          for (k = 0; k < HALF; k++) begin
            book_ids.delete(0);
            book_times.delete(0);
          end
          rpt.evicted = 1'b1;
          evictions++;
        end
        book_ids.insert(book_ids.size(), id);
        book_times.insert(book_times.size(), ts);
      end
      MODE_TRADE: begin
        trades_n = bump(trades_n);
      end
      MODE_REPLACE: begin
        replaces_n = bump(replaces_n);
      end
      MODE_CANCEL: begin
        cancels_n = bump(cancels_n);
        for (k = 0; k < book_ids.size(); k++) begin
          if (idx < 0 && book_ids[k] == id) idx = k;
        end
        if (idx >= 0) begin
          rest_ts     = book_times[idx];
          rpt.matched = 1'b1;
          match_total++;
          // Fleeting only when both times are known; an earlier cancel always counts.
          if (known_time(ts) && known_time(rest_ts)) begin
            if ($signed(ts) >= $signed(rest_ts)) begin
              diff    = ts - rest_ts;
              rpt.hit = (diff < {1'b0, window});
            end else begin
              rpt.hit = 1'b1;
            end
          end
          if (rpt.hit) begin
            fleets_n = bump(fleets_n);
            fleets_hit++;
          end
          book_ids.delete(idx);
          book_times.delete(idx);
        end
      end
      default: begin
      end
    endcase
    rpt.rests    = rests_n;
    rpt.trades   = trades_n;
    rpt.replaces = replaces_n;
    rpt.cancels  = cancels_n;
    rpt.fleets   = fleets_n;
    rpt.open     = OPEN_W'(book_ids.size());
    return rpt;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Reports are compared before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    order_report_t want;
    if (!rst_ni) begin
      book_ids.delete();
      book_times.delete();
      report_q.delete();
      rests_n    = '0;
      trades_n   = '0;
      replaces_n = '0;
      cancels_n  = '0;
      fleets_n   = '0;
      window     = WINDOW_RST;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          $error("report taken with no request waiting for one");
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("cancel_matched", 64'(want.matched), 64'(cancel_matched_i));
          check_field("fleeting_hit", 64'(want.hit), 64'(fleeting_hit_i));
          check_field("evicted", 64'(want.evicted), 64'(evicted_i));
          check_field("rest_count", 64'(want.rests), 64'(rest_count_i));
          check_field("trade_count", 64'(want.trades), 64'(trade_count_i));
          check_field("replace_count", 64'(want.replaces), 64'(replace_count_i));
          check_field("cancel_count", 64'(want.cancels), 64'(cancel_count_i));
          check_field("fleeting_count", 64'(want.fleets), 64'(fleeting_count_i));
          check_field("open_entries", 64'(want.open), 64'(open_entries_i));
          reports++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) window = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        report_q.insert(report_q.size(), predict_report(mode_i, order_id_i, timestamp_i));
      end
      pending_o <= report_q.size();
    end
  end

endmodule

[dv/tb_fleeting_order_tracker.sv]
`timescale 1ns / 1ps

module tb_fleeting_order_tracker;
  import fot_pkg::*;

  // Event kinds the block ignores.
  localparam logic [MODE_W-1:0] MODE_OTHER_LO = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OTHER_HI = 3'd7;

  localparam logic [TS_W-1:0]  TS_MAX  = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic [TS_W-1:0]  TS_MIN  = {1'b1, {(TS_W-1){1'b0}}};
  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam int unsigned      SETTLE_CYCLES = 12;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i      = '0;
  logic [ID_W-1:0]     order_id_i  = '0;
  logic signed [TS_W-1:0] timestamp_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [WIN_W-1:0]    cfg_data_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                cancel_matched_o;
  logic                fleeting_hit_o;
  logic                evicted_o;
  logic [CNT_W-1:0]    rest_count_o;
  logic [CNT_W-1:0]    trade_count_o;
  logic [CNT_W-1:0]    replace_count_o;
  logic [CNT_W-1:0]    cancel_count_o;
  logic [CNT_W-1:0]    fleeting_count_o;
  logic [OPEN_W-1:0]   open_entries_o;

  int unsigned mismatches, outstanding, reports, match_total, fleets, evictions;

  // Stimulus-side memory of rested orders, used to aim cancels at live entries.
  logic [ID_W-1:0]  rested_ids[$];
  logic [TS_W-1:0]  rested_times[$];
  logic [TS_W-1:0]  feed_clock = 64'd1_000_000_000;
  logic [WIN_W-1:0] window_now = WINDOW_RST;
  logic             in_calm    = 1'b0;
  logic             out_calm   = 1'b0;
  int unsigned      events_sent = 0;

  fleeting_order_tracker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .order_id_i       (order_id_i),
    .timestamp_i      (timestamp_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cancel_matched_o (cancel_matched_o),
    .fleeting_hit_o   (fleeting_hit_o),
    .evicted_o        (evicted_o),
    .rest_count_o     (rest_count_o),
    .trade_count_o    (trade_count_o),
    .replace_count_o  (replace_count_o),
    .cancel_count_o   (cancel_count_o),
    .fleeting_count_o (fleeting_count_o),
    .open_entries_o   (open_entries_o)
  );

  tb_fot_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .mode_i           (mode_i),
    .order_id_i       (order_id_i),
    .timestamp_i      (timestamp_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cancel_matched_i (cancel_matched_o),
    .fleeting_hit_i   (fleeting_hit_o),
    .evicted_i        (evicted_o),
    .rest_count_i     (rest_count_o),
    .trade_count_i    (trade_count_o),
    .replace_count_i  (replace_count_o),
    .cancel_count_i   (cancel_count_o),
    .fleeting_count_i (fleeting_count_o),
    .open_entries_i   (open_entries_o),
    .mismatches_o     (mismatches),
    .pending_o        (outstanding),
    .reports_o        (reports),
    .match_total_o    (match_total),
    .fleeting_o       (fleets),
    .evictions_o      (evictions)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Report sink: may stall at random before taking each report.
  always begin : report_sink
    int unsigned stall;
    stall = out_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
    if (stall > 0) begin
      out_ready_i <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    while (!out_valid_o) @(posedge clk_i);
  end

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                            input logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    order_id_i  <= id;
    timestamp_i <= ts;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic rest_order(input logic [ID_W-1:0] id, input logic [TS_W-1:0] ts);
    send_event(MODE_REST, id, ts);
    rested_ids.insert(rested_ids.size(), id);
    rested_times.insert(rested_times.size(), ts);
    if (rested_ids.size() > 2048) begin
      rested_ids.delete(0);
      rested_times.delete(0);
    end
  endtask

  // Stops offering requests and waits until every report has been taken.
  task automatic drain_events();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] win);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= win;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    window_now = win;
  endtask

  // One random event; weights are in 64ths, the remainder goes to the other kinds.
  task automatic random_event(input int unsigned w_rest, input int unsigned w_cancel);
    int unsigned     roll;
    int unsigned     pick;
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] rest_ts;
    logic [TS_W-1:0] span;
    roll = $urandom_range(0, 63);
    if (roll < w_rest) begin
      // Small ids recur so that the book holds duplicates.
      id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 15)) : {$urandom, $urandom};
      case ($urandom_range(0, 15))
        0:       ts = '0;
        1:       ts = {1'b1, 31'($urandom), $urandom};
        2:       ts = TS_MAX;
        3:       ts = {$urandom, $urandom};
        default: begin
          feed_clock = feed_clock + $urandom_range(1, 5000);
          ts         = feed_clock;
        end
      endcase
      rest_order(id, ts);
    end else if (roll < w_rest + w_cancel) begin
      if (rested_ids.size() > 0 && $urandom_range(0, 9) < 8) begin
        pick    = $urandom_range(0, rested_ids.size() - 1);
        id      = rested_ids[pick];
        rest_ts = rested_times[pick];
      end else begin
        id      = {$urandom, $urandom};
        rest_ts = feed_clock;
      end
      // Cancel time lands around the window edge, before the rest, or anywhere.
      case ($urandom_range(0, 9))
        0:       ts = '0;
        1:       ts = {1'b1, 31'($urandom), $urandom};
        2:       ts = {$urandom, $urandom};
        3:       ts = rest_ts + window_now - 1'b1;
        4:       ts = rest_ts + window_now;
        5:       ts = rest_ts - $urandom_range(1, 1000);
        default: begin
          span = ({1'b0, window_now} << 1) + 64'd1;
          ts   = rest_ts + ({$urandom, $urandom} % span);
        end
      endcase
      send_event(MODE_CANCEL, id, ts);
    end else begin
      id = {$urandom, $urandom};
      ts = {$urandom, $urandom};
      case ($urandom_range(0, 2))
        0:       send_event(MODE_TRADE, id, ts);
        1:       send_event(MODE_REPLACE, id, ts);
        default: send_event(3'($urandom_range(MODE_OTHER_LO, MODE_OTHER_HI)), id, ts);
      endcase
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset window: other kinds, empty-book cancel,
    // oldest-duplicate match, unknown times and a cancel before its rest.
    send_event(MODE_TRADE, '1, TS_MIN);
    send_event(MODE_REPLACE, '0, TS_MAX);
    send_event(MODE_OTHER_LO, 64'h0123_4567_89ab_cdef, 64'd100);
    send_event(MODE_OTHER_LO + 3'd1, 64'h5, 64'd100);
    send_event(MODE_OTHER_HI - 3'd1, 64'h6, 64'd100);
    send_event(MODE_OTHER_HI, '1, TS_MIN);
    send_event(MODE_CANCEL, '0, 64'd10);
    rest_order(64'hA, 64'd1000);
    rest_order(64'hA, 64'd5000);
    rest_order('1, '0);
    rest_order(64'hC, TS_MIN);
    rest_order(64'hD, TS_MAX);
    send_event(MODE_CANCEL, 64'hA, 64'd1000 + WINDOW_RST - 1);
    send_event(MODE_CANCEL, 64'hA, 64'd5000 + WINDOW_RST);
    send_event(MODE_CANCEL, '1, 64'd100);
    send_event(MODE_CANCEL, 64'hC, 64'd100);
    send_event(MODE_CANCEL, 64'hD, 64'd5);
    send_event(MODE_CANCEL, 64'hA, 64'd6000);
    drain_events();

    // Zero window: equal times miss, an earlier cancel still counts.
    write_window('0);
    rest_order(64'hE, 64'd777);
    send_event(MODE_CANCEL, 64'hE, 64'd777);
    rest_order(64'hF, 64'd10);
    send_event(MODE_CANCEL, 64'hF, 64'd9);
    drain_events();

    // Short window with a busy mix of events.
    write_window(WIN_W'(1000));
    repeat (150) random_event(26, 22);
    drain_events();

    // Widest window while the book fills past capacity.
    write_window(WIN_MAX);
    repeat (1100) random_event(61, 2);
    drain_events();

    // Random window with cancels dominating.
    write_window(WIN_W'($urandom_range(1, 2_000_000)));
    repeat (150) random_event(18, 34);
    drain_events();

    $display("Ran %0d order events under five window settings; %0d reports compared.",
             events_sent, reports);
    $display("Cancels matched %0d, fleeting %0d, half-book evictions %0d.",
             match_total, fleets, evictions);
    if (mismatches == 0 && outstanding == 0) begin
      $display("fleeting_order_tracker regression: pass");
    end else begin
      $display("fleeting_order_tracker regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d reports still outstanding.", outstanding);
    $display("fleeting_order_tracker regression: fail");
    $finish;
  end

endmodule

[fleeting_order_tracker.f]
rtl/core/fot_pkg.sv
rtl/core/fot_cell.sv
rtl/core/fot_search.sv
rtl/core/fleeting_order_tracker.sv
rtl/core/fot_checker.sv
dv/fot_checker.sv
dv/tb_fleeting_order_tracker.sv
